### rtl/core/wms_pkg.sv
package wms_pkg;

    // Fixed field widths of the item and result transfers.
    localparam int KMER_W  = 64;
    localparam int START_W = 20;
    localparam int POS_W   = 22;
    localparam int OFFS_W  = 9;

    // Shift amounts of the 64-bit shift-add-xor mixing hash.
    localparam int SH_A = 21;
    localparam int SH_B = 24;
    localparam int SH_C = 3;
    localparam int SH_D = 8;
    localparam int SH_E = 14;
    localparam int SH_F = 2;
    localparam int SH_G = 4;
    localparam int SH_H = 28;
    localparam int SH_I = 31;

    // Depth of the queue between the hash front and the selection back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One hashed k-mer as it travels from the front to the back.
    typedef struct packed {
        logic [KMER_W-1:0]  kmer;
        logic [KMER_W-1:0]  hash;
        logic               amb;
        logic [START_W-1:0] start;
        logic               last;
    } t_entry;

endpackage

### rtl/core/wms_if.sv
// Input item channel: one packed k-mer per transfer.
interface wms_item_if;
    logic                           valid;
    logic                           ready;
    logic [wms_pkg::KMER_W-1:0]     kmer_value;
    logic                           has_ambiguous;
    logic [wms_pkg::START_W-1:0]    window_start;
    logic                           last_item;

    modport source (output valid, kmer_value, has_ambiguous, window_start, last_item,
                    input ready);
    modport sink   (input valid, kmer_value, has_ambiguous, window_start, last_item,
                    output ready);
endinterface

// Result channel: one minimizer per window.
interface wms_result_if;
    logic                                valid;
    logic                                ready;
    logic [wms_pkg::KMER_W-1:0]          minimizer_kmer;
    logic signed [wms_pkg::POS_W-1:0]    minimizer_pos;
    logic signed [wms_pkg::OFFS_W-1:0]   offset_in_window;
    logic                                valid_res;

    modport source (output valid, minimizer_kmer, minimizer_pos, offset_in_window,
                    valid_res, input ready);
    modport sink   (input valid, minimizer_kmer, minimizer_pos, offset_in_window,
                    valid_res, output ready);
endinterface

### rtl/core/wms_front.sv
module wms_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wms_item_if.sink        i_item,
    output logic            o_valid,
    output wms_pkg::t_entry o_entry,
    input  logic            i_ready
);
    import wms_pkg::*;

    localparam int HASH_STAGES = 4;

    typedef struct packed {
        logic [KMER_W-1:0]  kmer;
        logic [KMER_W-1:0]  work;
        logic               ones;
        logic               amb;
        logic [START_W-1:0] start;
        logic               last;
    } t_stage;

    function automatic logic [KMER_W-1:0] mix_a(input logic [KMER_W-1:0] k);
        logic [KMER_W-1:0] t;
        t = (~k) + (k << SH_A);
        return t ^ (t >> SH_B);
    endfunction

    function automatic logic [KMER_W-1:0] mix_b(input logic [KMER_W-1:0] k);
        logic [KMER_W-1:0] t;
        t = (k + (k << SH_C)) + (k << SH_D);
        return t ^ (t >> SH_E);
    endfunction

    function automatic logic [KMER_W-1:0] mix_c(input logic [KMER_W-1:0] k);
        logic [KMER_W-1:0] t;
        t = (k + (k << SH_F)) + (k << SH_G);
        return t ^ (t >> SH_H);
    endfunction

    function automatic logic [KMER_W-1:0] mix_d(input logic [KMER_W-1:0] k);
        return k + (k << SH_I);
    endfunction

    logic [HASH_STAGES-1:0] r_vld;
    t_stage                 r_stg [HASH_STAGES];
    t_stage                 n_stg [HASH_STAGES];
    logic                   adv;

    // The whole pipeline moves when its last stage is empty or drains into the queue.
    assign adv          = !r_vld[HASH_STAGES-1] || i_ready;
    assign i_item.ready = adv;

    // One mixing round per stage; the all-ones key is marked for bypass.
    always_comb begin
        n_stg[0].kmer  = i_item.kmer_value;
        n_stg[0].work  = mix_a(i_item.kmer_value);
        n_stg[0].ones  = &i_item.kmer_value;
        n_stg[0].amb   = i_item.has_ambiguous;
        n_stg[0].start = i_item.window_start;
        n_stg[0].last  = i_item.last_item;
        n_stg[1]       = r_stg[0];
        n_stg[1].work  = mix_b(r_stg[0].work);
        n_stg[2]       = r_stg[1];
        n_stg[2].work  = mix_c(r_stg[1].work);
        n_stg[3]       = r_stg[2];
        n_stg[3].work  = mix_d(r_stg[2].work);
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[HASH_STAGES-2:0], i_item.valid};
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stg <= n_stg;
        end
    end

    // The final stage forms the queue entry.
    always_comb begin
        o_valid       = r_vld[HASH_STAGES-1];
        o_entry.kmer  = r_stg[HASH_STAGES-1].kmer;
        o_entry.hash  = r_stg[HASH_STAGES-1].ones ? '1 : r_stg[HASH_STAGES-1].work;
        o_entry.amb   = r_stg[HASH_STAGES-1].amb;
        o_entry.start = r_stg[HASH_STAGES-1].start;
        o_entry.last  = r_stg[HASH_STAGES-1].last;
    end

endmodule

### rtl/core/wms_queue.sv
module wms_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  wms_pkg::t_entry i_entry,
    output logic            o_ready,
    output logic            o_valid,
    output wms_pkg::t_entry o_entry,
    input  logic            i_ready
);
    import wms_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 push;
    logic                 pop;

    assign o_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_entry = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue fill count above depth");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a transfer in");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> r_count != '0)
        else $error("queue read while empty");

endmodule

### rtl/core/wms_back.sv
module wms_back #(
    parameter int MAX_WINDOW    = 256,
    parameter int READ_POS_BITS = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  wms_pkg::t_entry i_entry,
    output logic            o_ready,
    wms_result_if.source    o_result
);
    import wms_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int OFF_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int BASE_W = (READ_POS_BITS < START_W) ? READ_POS_BITS : START_W;

    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic              r_inv,  n_inv;
    logic [KMER_W-1:0] r_kmer, n_kmer;
    logic [KMER_W-1:0] r_hash, n_hash;
    logic [OFF_W-1:0]  r_off,  n_off;
    logic [BASE_W-1:0] r_base, n_base;

    logic              r_o_valid;
    logic [KMER_W-1:0] r_o_kmer;
    logic [POS_W-1:0]  r_o_pos;
    logic [OFFS_W-1:0] r_o_offs;
    logic              r_o_res;

    logic              out_free;
    logic              pop;
    logic [POS_W-1:0]  pos_sum;
    logic [OFFS_W-1:0] off_ext;

    // A last item needs the result register; other items always go through.
    assign out_free = !r_o_valid || o_result.ready;
    assign pop      = i_valid && (!i_entry.last || out_free);
    assign o_ready  = !i_entry.last || out_free;

    // Selection update for one transfer.
    always_comb begin
        n_cnt  = r_cnt;
        n_inv  = r_inv;
        n_kmer = r_kmer;
        n_hash = r_hash;
        n_off  = r_off;
        n_base = r_base;
        if (r_cnt == '0) begin
            n_base = i_entry.start[BASE_W-1:0];
            n_kmer = i_entry.kmer;
            n_hash = i_entry.hash;
            n_off  = '0;
            n_inv  = i_entry.amb;
            n_cnt  = CNT_W'(1);
        end else if (r_cnt < CNT_W'(MAX_WINDOW)) begin
            if (!r_inv) begin
                if (i_entry.amb) begin
                    n_inv = 1'b1;
                end else if (i_entry.hash <= r_hash) begin
                    n_kmer = i_entry.kmer;
                    n_hash = i_entry.hash;
                    n_off  = r_cnt[OFF_W-1:0];
                end
            end
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_inv = 1'b1;
        end
    end

    assign pos_sum = POS_W'(n_base) + POS_W'(n_off);
    assign off_ext = OFFS_W'(n_off);

    // Window control state; a last item closes the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_inv <= 1'b0;
        end else if (pop) begin
            if (i_entry.last) begin
                r_cnt <= '0;
                r_inv <= 1'b0;
            end else begin
                r_cnt <= n_cnt;
                r_inv <= n_inv;
            end
        end
    end

    // Best candidate so far.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kmer <= n_kmer;
            r_hash <= n_hash;
            r_off  <= n_off;
            r_base <= n_base;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (pop && i_entry.last) begin
            r_o_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (pop && i_entry.last) begin
            r_o_kmer <= n_kmer;
            r_o_res  <= !n_inv;
            r_o_pos  <= n_inv ? '1 : pos_sum;
            r_o_offs <= n_inv ? '1 : off_ext;
        end
    end

    assign o_result.valid              = r_o_valid;
    assign o_result.minimizer_kmer     = r_o_kmer;
    assign o_result.minimizer_pos      = r_o_pos;
    assign o_result.offset_in_window   = r_o_offs;
    assign o_result.valid_res          = r_o_res;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_WINDOW))
        else $error("item count above window bound");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_entry.last |=> r_cnt == '0 && r_o_valid)
        else $error("window not closed after last item");

    a_off_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != '0 |-> CNT_W'(r_off) < r_cnt)
        else $error("best offset beyond items taken");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !o_result.ready |-> !(pop && i_entry.last))
        else $error("pending result overwritten");

endmodule

### rtl/core/window_minimizer_select.sv
// Path: a last item's result passes through the 4 hash stages, the queue
// and then the result register.
// Throughput: one k-mer per cycle unless a last item waits on a pending result;
// the hash pipeline stalls only when the queue fills.
// Reset clears all control state at once; no clearing pass is needed.
module window_minimizer_select #(
    parameter int MAX_WINDOW    = 256,
    parameter int READ_POS_BITS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wms_item_if.sink      i_item,
    wms_result_if.source  o_result
);
    import wms_pkg::*;

    logic   f_valid;
    logic   f_ready;
    t_entry f_entry;
    logic   b_valid;
    logic   b_ready;
    t_entry b_entry;

    // Hash pipeline.
    wms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_entry (f_entry),
        .i_ready (f_ready)
    );

    // Decoupling queue.
    wms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_entry (f_entry),
        .o_ready (f_ready),
        .o_valid (b_valid),
        .o_entry (b_entry),
        .i_ready (b_ready)
    );

    // Minimum selection and result register.
    wms_back #(
        .MAX_WINDOW    (MAX_WINDOW),
        .READ_POS_BITS (READ_POS_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (b_valid),
        .i_entry  (b_entry),
        .o_ready  (b_ready),
        .o_result (o_result)
    );

endmodule
